>>> src/mma_pkg.sv
// Shared types and constants for the matrix multiply-accumulate block.
// No dependencies; imported by every module under src.
package mma_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int IDX_W       = 3;
    localparam int SIZE_W      = 4;
    localparam int FACTOR_W    = 16;
    localparam int ACCUM_W     = 48;
    localparam int PROD_W      = 2 * FACTOR_W;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_LOAD_C  = 2'd2,
        OP_COMPUTE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPUTE,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } t_state;

    typedef struct packed {
        logic [1:0]                 operation;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           col;
        logic signed [FACTOR_W-1:0] factor_value;
        logic signed [ACCUM_W-1:0]  accum_value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic signed [ACCUM_W-1:0] product_value;
        logic                      last;
    } t_out_item;

    // write enables toward the matrix memories
    typedef struct packed {
        logic a_we;
        logic b_we;
        logic c_we;
    } t_mem_en;

    // per-term tag that travels with the memory read data into the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last_k;
    } t_mac_tag;

endpackage

>>> src/matrix_multiply_accumulate.sv
// Load items: one per cycle while idle, no result. Compute item: n^3 terms
// of multiply-accumulate (one term per cycle, set by the single A/B read
// port), a drain of the MAC pipeline, then each C element in turn through
// the EMIT_RD, EMIT_LD and EMIT_WAIT states, which holds for output stalls.
// Synchronous active-low reset clears control state and sets matrix_size to
// MAX_DIM; matrix memory contents are undefined until written.
module matrix_multiply_accumulate import mma_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in_item          i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out_item         o_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    t_mem_en                    mem_en;
    logic [ADDR_W-1:0]          ab_waddr, c_waddr, a_raddr, b_raddr, c_raddr;
    logic signed [ACCUM_W-1:0]  c_wdata;
    logic signed [FACTOR_W-1:0] rd_a, rd_b;
    logic signed [ACCUM_W-1:0]  rd_c;
    t_mac_tag                   tag;
    logic [ADDR_W-1:0]          tag_addr;
    t_mac_tag                   r_tag_s1;
    logic [ADDR_W-1:0]          r_tag_addr_s1;
    logic                       mac_busy, wb_en;
    logic [ADDR_W-1:0]          wb_addr;
    logic signed [ACCUM_W-1:0]  wb_data;

    mma_ctrl #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_en        (mem_en),
        .o_ab_waddr  (ab_waddr),
        .o_c_waddr   (c_waddr),
        .o_c_wdata   (c_wdata),
        .o_a_raddr   (a_raddr),
        .o_b_raddr   (b_raddr),
        .o_c_raddr   (c_raddr),
        .i_rd_c      (rd_c),
        .o_tag       (tag),
        .o_tag_addr  (tag_addr),
        .i_mac_busy  (mac_busy),
        .i_wb_en     (wb_en),
        .i_wb_addr   (wb_addr),
        .i_wb_data   (wb_data)
    );

    mma_store #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_en       (mem_en),
        .i_ab_waddr (ab_waddr),
        .i_factor   (i_item.factor_value),
        .i_c_waddr  (c_waddr),
        .i_c_wdata  (c_wdata),
        .i_a_raddr  (a_raddr),
        .i_b_raddr  (b_raddr),
        .i_c_raddr  (c_raddr),
        .o_a        (rd_a),
        .o_b        (rd_b),
        .o_c        (rd_c)
    );

    // align the term tag with the registered memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_s1 <= '0;
        end else begin
            r_tag_s1 <= tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_addr_s1 <= tag_addr;
    end

    mma_mac #(
        .ADDR_W (ADDR_W)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (r_tag_s1),
        .i_addr    (r_tag_addr_s1),
        .i_a       (rd_a),
        .i_b       (rd_b),
        .i_c       (rd_c),
        .o_busy    (mac_busy),
        .o_wb_en   (wb_en),
        .o_wb_addr (wb_addr),
        .o_wb_data (wb_data)
    );

endmodule

>>> src/mma_store.sv
// Matrix memories A, B and C: one write and one registered read port each.
// Depends on mma_pkg.
module mma_store import mma_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int ADDR_W  = 6
) (
    input  logic                       i_clk,
    input  t_mem_en                    i_en,
    input  logic [ADDR_W-1:0]          i_ab_waddr,
    input  logic signed [FACTOR_W-1:0] i_factor,
    input  logic [ADDR_W-1:0]          i_c_waddr,
    input  logic signed [ACCUM_W-1:0]  i_c_wdata,
    input  logic [ADDR_W-1:0]          i_a_raddr,
    input  logic [ADDR_W-1:0]          i_b_raddr,
    input  logic [ADDR_W-1:0]          i_c_raddr,
    output logic signed [FACTOR_W-1:0] o_a,
    output logic signed [FACTOR_W-1:0] o_b,
    output logic signed [ACCUM_W-1:0]  o_c
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic signed [FACTOR_W-1:0] r_mem_a [DEPTH];
    logic signed [FACTOR_W-1:0] r_mem_b [DEPTH];
    logic signed [ACCUM_W-1:0]  r_mem_c [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en.a_we) begin
            r_mem_a[i_ab_waddr] <= i_factor;
        end
        o_a <= r_mem_a[i_a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.b_we) begin
            r_mem_b[i_ab_waddr] <= i_factor;
        end
        o_b <= r_mem_b[i_b_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.c_we) begin
            r_mem_c[i_c_waddr] <= i_c_wdata;
        end
        o_c <= r_mem_c[i_c_raddr];
    end

endmodule

>>> src/mma_mac.sv
// Multiply-accumulate pipeline: registered product, saturating 48-bit sum,
// write-back of each finished C element. Depends on mma_pkg.
module mma_mac import mma_pkg::*; #(
    parameter int ADDR_W = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_tag                   i_tag,
    input  logic [ADDR_W-1:0]          i_addr,
    input  logic signed [FACTOR_W-1:0] i_a,
    input  logic signed [FACTOR_W-1:0] i_b,
    input  logic signed [ACCUM_W-1:0]  i_c,
    output logic                       o_busy,
    output logic                       o_wb_en,
    output logic [ADDR_W-1:0]          o_wb_addr,
    output logic signed [ACCUM_W-1:0]  o_wb_data
);

    localparam logic signed [ACCUM_W-1:0] SUM_MAX = {1'b0, {(ACCUM_W-1){1'b1}}};
    localparam logic signed [ACCUM_W-1:0] SUM_MIN = {1'b1, {(ACCUM_W-1){1'b0}}};

    t_mac_tag                   r_tag2;
    logic [ADDR_W-1:0]          r_addr2;
    logic signed [PROD_W-1:0]   r_prod2;
    logic signed [ACCUM_W-1:0]  r_c2;
    logic signed [ACCUM_W-1:0]  r_acc;
    logic signed [ACCUM_W-1:0]  n_acc;
    logic signed [ACCUM_W-1:0]  base;
    logic signed [ACCUM_W:0]    sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
        end else begin
            r_tag2 <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr2 <= i_addr;
        r_prod2 <= i_a * i_b;
        r_c2    <= i_c;
        if (r_tag2.valid) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        base = r_tag2.first ? r_c2 : r_acc;
        sum  = (ACCUM_W+1)'(base) + (ACCUM_W+1)'(r_prod2);
        // clamp when the carry out disagrees with the sign bit
        if (sum[ACCUM_W] != sum[ACCUM_W-1]) begin
            n_acc = sum[ACCUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_acc = sum[ACCUM_W-1:0];
        end
    end

    assign o_busy    = r_tag2.valid;
    assign o_wb_en   = r_tag2.valid && r_tag2.last_k;
    assign o_wb_addr = r_addr2;
    assign o_wb_data = n_acc;

endmodule

>>> src/mma_ctrl.sv
// Sequencer: load handling, i/j/k loop counters, read addressing, result
// emission through the output register. Depends on mma_pkg.
module mma_ctrl import mma_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int ADDR_W  = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_in_item                   i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_out_item                  o_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [SIZE_W-1:0]          i_cfg_data,
    output t_mem_en                    o_en,
    output logic [ADDR_W-1:0]          o_ab_waddr,
    output logic [ADDR_W-1:0]          o_c_waddr,
    output logic signed [ACCUM_W-1:0]  o_c_wdata,
    output logic [ADDR_W-1:0]          o_a_raddr,
    output logic [ADDR_W-1:0]          o_b_raddr,
    output logic [ADDR_W-1:0]          o_c_raddr,
    input  logic signed [ACCUM_W-1:0]  i_rd_c,
    output t_mac_tag                   o_tag,
    output logic [ADDR_W-1:0]          o_tag_addr,
    input  logic                       i_mac_busy,
    input  logic                       i_wb_en,
    input  logic [ADDR_W-1:0]          i_wb_addr,
    input  logic signed [ACCUM_W-1:0]  i_wb_data
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_i, n_i, r_j, n_j, r_k, n_k;
    logic [SIZE_W-1:0] r_size;
    t_mac_tag          r_s1_tag;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [SIZE_W-1:0] act_size;
    logic [IDX_W-1:0]  nm1;
    logic              in_range;
    logic              load_c;
    logic              last_elem;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= SIZE_W'(MAX_DIM);
            r_s1_tag    <= '0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_s1_tag    <= o_tag;
            r_out_valid <= n_out_valid;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        if (r_size == '0) begin
            act_size = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_DIM)) begin
            act_size = SIZE_W'(MAX_DIM);
        end else begin
            act_size = r_size;
        end
    end

    assign nm1       = IDX_W'(act_size - SIZE_W'(1));
    assign in_range  = ({1'b0, i_item.row} < SIZE_W'(MAX_DIM)) &&
                       ({1'b0, i_item.col} < SIZE_W'(MAX_DIM));
    assign last_elem = (r_i == nm1) && (r_j == nm1);

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_ready     = 1'b0;
        o_en        = '0;
        load_c      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (t_op'(i_item.operation))
                        OP_LOAD_A: o_en.a_we = in_range;
                        OP_LOAD_B: o_en.b_we = in_range;
                        OP_LOAD_C: load_c    = in_range;
                        OP_COMPUTE: begin
                            n_i     = '0;
                            n_j     = '0;
                            n_k     = '0;
                            n_state = ST_COMPUTE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_COMPUTE: begin
                // advance k, then j, then i
                if (r_k != nm1) begin
                    n_k = r_k + IDX_W'(1);
                end else begin
                    n_k = '0;
                    if (r_j != nm1) begin
                        n_j = r_j + IDX_W'(1);
                    end else begin
                        n_j = '0;
                        if (r_i != nm1) begin
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_i     = '0;
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                // hold until the last C write-back has landed
                if (!r_s1_tag.valid && !i_mac_busy) begin
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: n_state = ST_EMIT_LD;
            ST_EMIT_LD: begin
                n_out.out_row       = r_i;
                n_out.out_col       = r_j;
                n_out.product_value = i_rd_c;
                n_out.last          = last_elem;
                n_out_valid         = 1'b1;
                n_state             = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    if (last_elem) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT_RD;
                        if (r_j != nm1) begin
                            n_j = r_j + IDX_W'(1);
                        end else begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_en.c_we = load_c || i_wb_en;
    end

    assign o_cfg_ready  = 1'b1;
    assign o_ab_waddr   = f_addr(i_item.row, i_item.col);
    assign o_c_waddr    = load_c ? f_addr(i_item.row, i_item.col) : i_wb_addr;
    assign o_c_wdata    = load_c ? i_item.accum_value : i_wb_data;
    assign o_a_raddr    = f_addr(r_i, r_k);
    assign o_b_raddr    = f_addr(r_k, r_j);
    assign o_c_raddr    = f_addr(r_i, r_j);
    assign o_tag.valid  = (r_state == ST_COMPUTE);
    assign o_tag.first  = (r_k == '0);
    assign o_tag.last_k = (r_k == nm1);
    assign o_tag_addr   = f_addr(r_i, r_j);
    assign o_valid      = r_out_valid;
    assign o_item       = r_out;

`ifndef SYNTHESIS
    a_out_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_EMIT_WAIT))
        else $error("result shown outside emit wait");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && r_out_valid))
        else $error("input accepted while a result is pending");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_RD) |-> (!r_s1_tag.valid && !i_mac_busy && !i_wb_en))
        else $error("emission started before the MAC pipeline drained");

    a_no_wb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !i_wb_en)
        else $error("C write-back collides with a load");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for matrix_multiply_accumulate: directed table, then random
// load/compute rounds, all results checked in order. Depends on src/mma_pkg.sv.
module tb_top;
    import mma_pkg::*;

    localparam int          CELLS       = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam int          RAND_ITEMS  = 400;
    localparam int          IDLE_END    = 360;
    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam longint      SUM_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      SUM_MIN     = 64'shFFFF_8000_0000_0000;
    localparam logic [47:0] ACC_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ACC_MIN     = 48'h8000_0000_0000;

    typedef struct packed {
        bit                  is_cfg;
        logic [SIZE_W-1:0]   size;
        t_in_item            item;
        bit                  typed;
        logic [ACCUM_W-1:0]  typed_val;
    } t_step;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    t_in_item          i_item;
    logic              o_valid;
    logic              i_ready;
    t_out_item         o_item;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data;

    // mirror of the block's matrices and size register
    logic signed [FACTOR_W-1:0] a_mem [CELLS];
    logic signed [FACTOR_W-1:0] b_mem [CELLS];
    logic signed [ACCUM_W-1:0]  c_mem [CELLS];
    bit                         a_set [CELLS];
    bit                         b_set [CELLS];
    bit                         c_set [CELLS];
    logic [SIZE_W-1:0]          size_reg;

    t_out_item c_elem_q [$];
    t_step     plan [$];

    int  items_sent;
    int  directed_items;
    int  compute_cnt;
    int  results_seen;
    int  sat_hits;
    int  fail_cnt;
    int  cycle_cnt;
    bit  idle_on;

    matrix_multiply_accumulate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int eff_size(input logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(v);
    endfunction

    function automatic logic [FACTOR_W-1:0] rand_factor();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return FACTOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [ACCUM_W-1:0] rand_accum();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return ACC_MAX - r[37:0];
            1: return ACC_MIN + r[37:0];
            2: return {{16{r[31]}}, r[31:0]};
            default: return r[47:0];
        endcase
    endfunction

    function automatic t_in_item make_item(input t_op op, input logic [IDX_W-1:0] r,
                                           input logic [IDX_W-1:0] c);
        t_in_item it;
        it.operation    = op;
        it.row          = r;
        it.col          = c;
        it.factor_value = rand_factor();
        it.accum_value  = rand_accum();
        return it;
    endfunction

    function automatic t_step step_load(input t_op op, input logic [IDX_W-1:0] r,
                                        input logic [IDX_W-1:0] c,
                                        input logic [FACTOR_W-1:0] f,
                                        input logic [ACCUM_W-1:0] a);
        t_step s;
        s           = '0;
        s.item      = {op, r, c, f, a};
        return s;
    endfunction

    function automatic t_step step_cfg(input logic [SIZE_W-1:0] v);
        t_step s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.size   = v;
        return s;
    endfunction

    // ignored fields of a compute transaction are driven all ones
    function automatic t_step step_mac(input bit typed, input logic [ACCUM_W-1:0] v);
        t_step s;
        s                = '1;
        s.is_cfg         = 1'b0;
        s.size           = '0;
        s.item.operation = OP_COMPUTE;
        s.typed          = typed;
        s.typed_val      = v;
        return s;
    endfunction

    // Update the mirror for one accepted transaction; a compute queues every C element of the active square.
    task automatic apply_item(input t_in_item it, input bit typed,
                              input logic [ACCUM_W-1:0] typed_val);
        int        idx;
        int        n;
        longint    acc;
        t_out_item res;
        idx = it.row * MAX_DIM_DEF + it.col;
        case (it.operation)
            OP_LOAD_A: begin
                a_mem[idx] = it.factor_value;
                a_set[idx] = 1'b1;
            end
            OP_LOAD_B: begin
                b_mem[idx] = it.factor_value;
                b_set[idx] = 1'b1;
            end
            OP_LOAD_C: begin
                c_mem[idx] = it.accum_value;
                c_set[idx] = 1'b1;
            end
            default: begin
                compute_cnt++;
                n = eff_size(size_reg);
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        acc = longint'(c_mem[i * MAX_DIM_DEF + j]);
                        for (int k = 0; k < n; k++) begin
                            acc += longint'(a_mem[i * MAX_DIM_DEF + k]) *
                                   longint'(b_mem[k * MAX_DIM_DEF + j]);
                            if (acc > SUM_MAX) begin
                                acc = SUM_MAX;
                                sat_hits++;
                            end else if (acc < SUM_MIN) begin
                                acc = SUM_MIN;
                                sat_hits++;
                            end
                        end
                        c_mem[i * MAX_DIM_DEF + j] = acc[ACCUM_W-1:0];
                    end
                end
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        res.out_row       = IDX_W'(i);
                        res.out_col       = IDX_W'(j);
                        res.product_value = typed ? typed_val : c_mem[i * MAX_DIM_DEF + j];
                        res.last          = (i == n - 1) && (j == n - 1);
                        c_elem_q.push_back(res);
                    end
                end
            end
        endcase
    endtask

    task automatic send_item(input t_in_item it, input bit typed,
                             input logic [ACCUM_W-1:0] typed_val);
        if (idle_on && items_sent < IDLE_END && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        apply_item(it, typed, typed_val);
    endtask

    // Write matrix_size only once the block has drained.
    task automatic write_size(input logic [SIZE_W-1:0] v);
        i_valid <= 1'b0;
        while (c_elem_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        size_reg = v;
    endtask

    // Load every entry in the active square that has never been written.
    task automatic fill_active();
        int n;
        int idx;
        n = eff_size(size_reg);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                idx = r * MAX_DIM_DEF + c;
                if (!a_set[idx])
                    send_item(make_item(OP_LOAD_A, IDX_W'(r), IDX_W'(c)), 1'b0, '0);
                if (!b_set[idx])
                    send_item(make_item(OP_LOAD_B, IDX_W'(r), IDX_W'(c)), 1'b0, '0);
                if (!c_set[idx])
                    send_item(make_item(OP_LOAD_C, IDX_W'(r), IDX_W'(c)), 1'b0, '0);
            end
        end
    endtask

    task automatic note_error(input string what, input t_out_item want, input t_out_item got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display({"%0t %s: expected row %0d col %0d value %h last %b, ",
                      "got row %0d col %0d value %h last %b"},
                     $time, what, want.out_row, want.out_col, want.product_value, want.last,
                     got.out_row, got.out_col, got.product_value, got.last);
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            results_seen++;
            if (c_elem_q.size() == 0) begin
                note_error("unexpected result", '0, o_item);
            end else begin
                want = c_elem_q.pop_front();
                if (o_item.out_row !== want.out_row || o_item.out_col !== want.out_col ||
                    o_item.product_value !== want.product_value || o_item.last !== want.last)
                    note_error("result mismatch", want, o_item);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     c_elem_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // output-side backpressure
    initial begin : ready_gen
        int unsigned run_len;
        i_ready <= 1'b0;
        forever begin
            if (idle_on && items_sent < IDLE_END && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            run_len = $urandom_range(1, 24);
            i_ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [SIZE_W-1:0] size_seq [12];
        int phase;
        int rounds;
        int nload;

        size_seq    = '{4'd3, 4'd8, 4'd1, 4'd15, 4'd5, 4'd2,
                        4'd0, 4'd7, 4'd4, 4'd8, 4'd6, 4'd9};
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        size_reg    = MAX_DIM_DEF;
        idle_on     = 1'b1;
        for (int i = 0; i < CELLS; i++) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
            c_mem[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // saturation at both ends on a 1x1 matrix
        plan.push_back(step_cfg(4'd1));
        plan.push_back(step_load(OP_LOAD_A, 3'd0, 3'd0, 16'h8000, '1));
        plan.push_back(step_load(OP_LOAD_B, 3'd0, 3'd0, 16'h8000, '1));
        plan.push_back(step_load(OP_LOAD_C, 3'd0, 3'd0, 16'hFFFF, ACC_MAX));
        plan.push_back(step_mac(1'b1, ACC_MAX));
        plan.push_back(step_load(OP_LOAD_C, 3'd0, 3'd0, 16'h0000, ACC_MIN));
        plan.push_back(step_load(OP_LOAD_A, 3'd0, 3'd0, 16'h7FFF, '0));
        plan.push_back(step_load(OP_LOAD_B, 3'd0, 3'd0, 16'h8000, '0));
        plan.push_back(step_mac(1'b1, ACC_MIN));
        // loads outside the active square are stored but not used by the directed computes
        plan.push_back(step_load(OP_LOAD_A, 3'd7, 3'd7, 16'h7FFF, '1));
        plan.push_back(step_load(OP_LOAD_B, 3'd7, 3'd0, 16'h1234, '1));
        plan.push_back(step_load(OP_LOAD_C, 3'd0, 3'd7, 16'hFFFF, 48'h0001_2345_6789));
        // a size of zero acts as one
        plan.push_back(step_cfg(4'd0));
        plan.push_back(step_load(OP_LOAD_C, 3'd0, 3'd0, 16'h5555, '0));
        plan.push_back(step_load(OP_LOAD_A, 3'd0, 3'd0, 16'h7FFF, '0));
        plan.push_back(step_load(OP_LOAD_B, 3'd0, 3'd0, 16'h7FFF, '0));
        plan.push_back(step_mac(1'b1, 48'h0000_3FFF_0001));
        plan.push_back(step_cfg(4'd2));
        plan.push_back(step_load(OP_LOAD_A, 3'd0, 3'd1, 16'h8000, '0));
        plan.push_back(step_load(OP_LOAD_A, 3'd1, 3'd0, 16'h7FFF, '0));
        plan.push_back(step_load(OP_LOAD_A, 3'd1, 3'd1, 16'h0001, '0));
        plan.push_back(step_load(OP_LOAD_B, 3'd0, 3'd1, 16'hFFFF, '0));
        plan.push_back(step_load(OP_LOAD_B, 3'd1, 3'd0, 16'h8000, '0));
        plan.push_back(step_load(OP_LOAD_B, 3'd1, 3'd1, 16'h7FFF, '0));
        plan.push_back(step_load(OP_LOAD_C, 3'd0, 3'd1, 16'h0000, ACC_MAX));
        plan.push_back(step_load(OP_LOAD_C, 3'd1, 3'd0, 16'h0000, ACC_MIN));
        plan.push_back(step_load(OP_LOAD_C, 3'd1, 3'd1, 16'h0000, '0));
        plan.push_back(step_mac(1'b0, '0));

        for (int s = 0; s < plan.size(); s++) begin
            if (plan[s].is_cfg)
                write_size(plan[s].size);
            else
                send_item(plan[s].item, plan[s].typed, plan[s].typed_val);
        end
        directed_items = items_sent;

        // random rounds: scattered loads, fill the active square, then compute
        phase = 0;
        while (items_sent < directed_items + RAND_ITEMS) begin
            write_size(size_seq[phase % 12]);
            phase++;
            idle_on = ($urandom_range(0, 3) != 0);
            rounds  = $urandom_range(1, 3);
            for (int r = 0; r < rounds; r++) begin
                nload = $urandom_range(0, 20);
                for (int l = 0; l < nload; l++)
                    send_item(make_item(t_op'($urandom_range(0, 2)), IDX_W'($urandom),
                                        IDX_W'($urandom)), 1'b0, '0);
                fill_active();
                send_item(make_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom)),
                          1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (c_elem_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("summary: %0d transactions (%0d directed), %0d computes, %0d results checked",
                 items_sent, directed_items, compute_cnt, results_seen);
        $display("summary: sizes 0 through 9 and 15 applied, %0d saturated sums, %0d errors",
                 sat_hits, fail_cnt);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
src/mma_pkg.sv
src/mma_store.sv
src/mma_mac.sv
src/mma_ctrl.sv
src/matrix_multiply_accumulate.sv
sim/tb_top.sv
